@@ rtl/md4so_pkg.sv @@
// Package for the MD4 site occupancy oracle.
// Shared widths, chain constants, register indexes, lane type and MD4 step functions.
// No dependencies.
package md4so_pkg;

   localparam int unsigned WordWidth   = 32;
   localparam int unsigned Steps       = 48;
   localparam int unsigned StepWidth   = 6;
   localparam int unsigned CsrIdxWidth = 1;

   localparam logic [WordWidth-1:0] IvA = 32'h6745_2301;
   localparam logic [WordWidth-1:0] IvB = 32'hefcd_ab89;
   localparam logic [WordWidth-1:0] IvC = 32'h98ba_dcfe;
   localparam logic [WordWidth-1:0] IvD = 32'h1032_5476;

   localparam logic [WordWidth-1:0] KRound1 = 32'h5A82_7999;
   localparam logic [WordWidth-1:0] KRound2 = 32'h6ED9_EBA1;

   // padding word and bit length of the 12-byte message
   localparam logic [WordWidth-1:0] PadWord = 32'h0000_0080;
   localparam logic [WordWidth-1:0] LenWord = 32'd96;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_HASH_SEED      = 1'b0,
      CSR_OPEN_THRESHOLD = 1'b1
   } md4so_csr_idx_type;

   typedef struct packed {
      logic [WordWidth-1:0] a;
      logic [WordWidth-1:0] b;
      logic [WordWidth-1:0] c;
      logic [WordWidth-1:0] d;
      logic [WordWidth-1:0] y;
      logic [WordWidth-1:0] x;
   } md4so_lane_type;

   // block word position used by a step
   function automatic logic [3:0] msg_sel(input logic [StepWidth-1:0] step);
      logic [3:0] i;
      logic [3:0] sel;
      i = step[3:0];
      case (step[5:4])
         2'd0:    sel = i;
         2'd1:    sel = {i[1:0], i[3:2]};
         default: sel = {i[0], i[1], i[2], i[3]};
      endcase
      return sel;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [StepWidth-1:0] step);
      logic [4:0] s;
      case ({step[5:4], step[1:0]})
         4'b0000: s = 5'd3;
         4'b0001: s = 5'd7;
         4'b0010: s = 5'd11;
         4'b0011: s = 5'd19;
         4'b0100: s = 5'd3;
         4'b0101: s = 5'd5;
         4'b0110: s = 5'd9;
         4'b0111: s = 5'd13;
         4'b1000: s = 5'd3;
         4'b1001: s = 5'd9;
         4'b1010: s = 5'd11;
         default: s = 5'd15;
      endcase
      return s;
   endfunction

   function automatic logic [WordWidth-1:0] msg_word(
      input logic [3:0]           sel,
      input logic [WordWidth-1:0] seed,
      input logic [WordWidth-1:0] y,
      input logic [WordWidth-1:0] x
   );
      logic [WordWidth-1:0] w;
      case (sel)
         4'd0:    w = seed;
         4'd1:    w = y;
         4'd2:    w = x;
         4'd3:    w = PadWord;
         4'd14:   w = LenWord;
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic logic [WordWidth-1:0] round_fn(
      input logic [1:0]           rnd,
      input logic [WordWidth-1:0] b,
      input logic [WordWidth-1:0] c,
      input logic [WordWidth-1:0] d
   );
      logic [WordWidth-1:0] f;
      case (rnd)
         2'd0:    f = (b & c) | (~b & d);
         2'd1:    f = (b & c) | (b & d) | (c & d);
         default: f = b ^ c ^ d;
      endcase
      return f;
   endfunction

   function automatic logic [WordWidth-1:0] round_k(input logic [1:0] rnd);
      logic [WordWidth-1:0] k;
      case (rnd)
         2'd0:    k = '0;
         2'd1:    k = KRound1;
         default: k = KRound2;
      endcase
      return k;
   endfunction

endpackage

@@ rtl/md4so_if.sv @@
// Valid/ready channel interfaces: site request, occupancy response, register write.
// Depends on md4so_pkg.
interface md4so_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [md4so_pkg::WordWidth-1:0] site_x;
   logic signed [md4so_pkg::WordWidth-1:0] site_y;

   modport source (output valid, output site_x, output site_y, input ready);
   modport sink   (input valid, input site_x, input site_y, output ready);
endinterface

interface md4so_rsp_if;
   logic valid;
   logic ready;
   logic site_open;

   modport source (output valid, output site_open, input ready);
   modport sink   (input valid, input site_open, output ready);
endinterface

interface md4so_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [md4so_pkg::CsrIdxWidth-1:0]    index;
   logic [md4so_pkg::WordWidth-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/md4so_csr.sv @@
// Configuration registers: hash seed and open threshold.
// Depends on md4so_pkg and md4so_csr_if.
module md4so_csr (
   input  logic                            clock,
   input  logic                            reset,
   md4so_csr_if.sink                       csr_bus,
   output logic [md4so_pkg::WordWidth-1:0] hash_seed,
   output logic [md4so_pkg::WordWidth-1:0] open_threshold
);

   logic [md4so_pkg::WordWidth-1:0] hash_seed_ff;
   logic [md4so_pkg::WordWidth-1:0] hash_seed_in;
   logic [md4so_pkg::WordWidth-1:0] open_threshold_ff;
   logic [md4so_pkg::WordWidth-1:0] open_threshold_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      hash_seed_in      = hash_seed_ff;
      open_threshold_in = open_threshold_ff;
      if (csr_bus.valid) begin
         unique case (md4so_pkg::md4so_csr_idx_type'(csr_bus.index))
            md4so_pkg::CSR_HASH_SEED:      hash_seed_in      = csr_bus.data;
            md4so_pkg::CSR_OPEN_THRESHOLD: open_threshold_in = csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_seed_ff      <= '0;
         open_threshold_ff <= '0;
      end else begin
         hash_seed_ff      <= hash_seed_in;
         open_threshold_ff <= open_threshold_in;
      end
   end

   assign hash_seed      = hash_seed_ff;
   assign open_threshold = open_threshold_ff;

endmodule

@@ rtl/md4so_cell.sv @@
// One MD4 step cell of the hashing chain; registers the rotated state and the site words.
// Depends on md4so_pkg.
module md4so_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [md4so_pkg::StepWidth-1:0]   step,
   input  logic [md4so_pkg::WordWidth-1:0]   hash_seed,
   input  logic                              in_valid,
   input  md4so_pkg::md4so_lane_type         in_lane,
   output logic                              out_valid,
   output md4so_pkg::md4so_lane_type         out_lane
);

   logic                            valid_ff;
   logic                            valid_in;
   md4so_pkg::md4so_lane_type       lane_ff;
   md4so_pkg::md4so_lane_type       lane_in;
   logic [1:0]                      rnd;
   logic [md4so_pkg::WordWidth-1:0] sum;
   logic [2*md4so_pkg::WordWidth-1:0] dbl;

   assign rnd = step[5:4];

   always_comb begin
      sum = in_lane.a
          + md4so_pkg::round_fn(rnd, in_lane.b, in_lane.c, in_lane.d)
          + md4so_pkg::msg_word(md4so_pkg::msg_sel(step), hash_seed, in_lane.y, in_lane.x)
          + md4so_pkg::round_k(rnd);
      dbl = {sum, sum} << md4so_pkg::rot_amount(step);
      lane_in.a = in_lane.d;
      lane_in.d = in_lane.c;
      lane_in.c = in_lane.b;
      lane_in.b = dbl[2*md4so_pkg::WordWidth-1:md4so_pkg::WordWidth];
      lane_in.y = in_lane.y;
      lane_in.x = in_lane.x;
      valid_in  = advance ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule

@@ rtl/md4so_chain.sv @@
// Row of 48 MD4 step cells, one per step, advancing together.
// Depends on md4so_pkg and md4so_cell.
module md4so_chain (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic [md4so_pkg::WordWidth-1:0] hash_seed,
   input  logic                            in_valid,
   input  md4so_pkg::md4so_lane_type       in_lane,
   output logic                            out_valid,
   output md4so_pkg::md4so_lane_type       out_lane,
   output logic [md4so_pkg::Steps:0]       stage_valid
);

   md4so_pkg::md4so_lane_type stage_lane [md4so_pkg::Steps+1];

   assign stage_valid[0] = in_valid;
   assign stage_lane[0]  = in_lane;

   for (genvar g = 0; g < md4so_pkg::Steps; g++) begin : g_cell
      md4so_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .step      (md4so_pkg::StepWidth'(g)),
         .hash_seed (hash_seed),
         .in_valid  (stage_valid[g]),
         .in_lane   (stage_lane[g]),
         .out_valid (stage_valid[g+1]),
         .out_lane  (stage_lane[g+1])
      );
   end

   assign out_valid = stage_valid[md4so_pkg::Steps];
   assign out_lane  = stage_lane[md4so_pkg::Steps];

endmodule

@@ rtl/md4_site_occupancy_oracle.sv @@
// Top level of the MD4 site occupancy oracle.
// Depends on md4so_pkg, md4so_if, md4so_csr, md4so_chain.
//
// Takes one site per clock unless rsp_bus stalls; each req_bus transfer yields
// one site_open on rsp_bus via 48 MD4 step cells in a chain and the output
// register that adds the first IV word and compares against the threshold.
// A stall on rsp_bus freezes the chain and holds req_bus.ready low; bubbles on
// req_bus travel through the chain, not squeezed out. The user must write the
// registers (csr_bus, always ready) only while no site is in flight; unenforced.
module md4_site_occupancy_oracle (
   input  logic        clock,
   input  logic        reset,
   md4so_req_if.sink   req_bus,
   md4so_rsp_if.source rsp_bus,
   md4so_csr_if.sink   csr_bus
);

   logic [md4so_pkg::WordWidth-1:0] hash_seed;
   logic [md4so_pkg::WordWidth-1:0] open_threshold;
   logic                            advance;
   md4so_pkg::md4so_lane_type       head_lane;
   logic                            tail_valid;
   md4so_pkg::md4so_lane_type       tail_lane;
   logic [md4so_pkg::Steps:0]       stage_valid;
   logic [md4so_pkg::WordWidth-1:0] hash_word;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic                            site_open_ff;
   logic                            site_open_in;

   md4so_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_bus        (csr_bus),
      .hash_seed      (hash_seed),
      .open_threshold (open_threshold)
   );

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   always_comb begin
      head_lane.a = md4so_pkg::IvA;
      head_lane.b = md4so_pkg::IvB;
      head_lane.c = md4so_pkg::IvC;
      head_lane.d = md4so_pkg::IvD;
      head_lane.y = req_bus.site_y;
      head_lane.x = req_bus.site_x;
   end

   md4so_chain u_chain (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .hash_seed   (hash_seed),
      .in_valid    (req_bus.valid),
      .in_lane     (head_lane),
      .out_valid   (tail_valid),
      .out_lane    (tail_lane),
      .stage_valid (stage_valid)
   );

   always_comb begin
      hash_word    = tail_lane.a + md4so_pkg::IvA;
      rsp_valid_in = advance ? tail_valid : rsp_valid_ff;
      site_open_in = advance ? (hash_word < open_threshold) : site_open_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      site_open_ff <= site_open_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.site_open = site_open_ff;

   a_accept_enters_chain: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> stage_valid[1])
      else $error("transfer did not enter first cell");

   a_stall_freezes_chain: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |=> $stable(stage_valid[md4so_pkg::Steps:1]))
      else $error("chain moved during output stall");

   a_rsp_from_tail: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(tail_valid))
      else $error("response without finished hash");

   a_idle_chain_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (!rsp_bus.valid && !tail_valid) |=> !rsp_bus.valid)
      else $error("response appeared from empty chain");

endmodule
